[design/rbsi_pkg.sv]
// shared types and constants for the ray versus box slab test
// no dependencies; every other file refers to it by scoped names
package rbsi_pkg;

  localparam int AXES  = 3;
  localparam int LANES = 2 * AXES;
  localparam int NUM_W = 49;  // |bound - origin| * 2^16 magnitude
  localparam int DEN_W = 32;  // |dir| magnitude
  localparam int T_W   = 50;  // signed quotient and slab distance width

  localparam logic signed [T_W-1:0] NEG_UNB = {2'b11, {(T_W-2){1'b0}}};
  localparam logic signed [T_W-1:0] POS_UNB = {2'b00, {(T_W-2){1'b1}}};
  localparam logic signed [T_W-1:0] SAT_HI  = {{(T_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [T_W-1:0] SAT_LO  = {{(T_W-31){1'b1}}, {31{1'b0}}};

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
  } out_t;

  // one divider lane: numerator shifts out the top while quotient bits shift in
  typedef struct packed {
    logic [NUM_W-1:0] work;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    logic unb;   // zero direction, origin inside the slab
    logic miss;  // zero direction, origin outside the slab
  } axis_flag_t;

  typedef struct packed {
    div_lane_t  [LANES-1:0] lane;
    axis_flag_t [AXES-1:0]  flag;
  } div_pipe_t;

endpackage

[design/rbsi_prep.sv]
// front stage: slab differences, magnitudes and zero-direction flags
// depends on rbsi_pkg
module rbsi_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  rbsi_pkg::in_t      in_data,
  output logic               valid,
  output rbsi_pkg::div_pipe_t pipe
);

  logic signed [31:0] lo  [rbsi_pkg::AXES];
  logic signed [31:0] hi  [rbsi_pkg::AXES];
  logic signed [31:0] org [rbsi_pkg::AXES];
  logic signed [31:0] dir [rbsi_pkg::AXES];
  rbsi_pkg::div_pipe_t pipe_next;

  assign lo[0]  = in_data.box_min_x;
  assign lo[1]  = in_data.box_min_y;
  assign lo[2]  = in_data.box_min_z;
  assign hi[0]  = in_data.box_max_x;
  assign hi[1]  = in_data.box_max_y;
  assign hi[2]  = in_data.box_max_z;
  assign org[0] = in_data.origin_x;
  assign org[1] = in_data.origin_y;
  assign org[2] = in_data.origin_z;
  assign dir[0] = in_data.dir_x;
  assign dir[1] = in_data.dir_y;
  assign dir[2] = in_data.dir_z;

  always_comb begin
    logic signed [32:0] d_lo, d_hi;
    logic [32:0] m_lo, m_hi;
    logic [31:0] dmag;
    logic zero, org_in;
    pipe_next = '0;
    for (int a = 0; a < rbsi_pkg::AXES; a++) begin
      d_lo = 33'(lo[a]) - 33'(org[a]);
      d_hi = 33'(hi[a]) - 33'(org[a]);
      m_lo = d_lo[32] ? 33'(-d_lo) : 33'(d_lo);
      m_hi = d_hi[32] ? 33'(-d_hi) : 33'(d_hi);
      dmag = dir[a][31] ? 32'(-dir[a]) : 32'(dir[a]);
      zero = (dir[a] == 32'sd0);
      org_in = (org[a] >= lo[a] && org[a] <= hi[a]) ||
               (org[a] >= hi[a] && org[a] <= lo[a]);
      pipe_next.lane[2*a].work   = {m_lo, 16'b0};
      pipe_next.lane[2*a].rem    = '0;
      pipe_next.lane[2*a].den    = dmag;
      pipe_next.lane[2*a].neg    = d_lo[32] ^ dir[a][31];
      pipe_next.lane[2*a+1].work = {m_hi, 16'b0};
      pipe_next.lane[2*a+1].rem  = '0;
      pipe_next.lane[2*a+1].den  = dmag;
      pipe_next.lane[2*a+1].neg  = d_hi[32] ^ dir[a][31];
      pipe_next.flag[a].unb  = zero & org_in;
      pipe_next.flag[a].miss = zero & ~org_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe <= pipe_next;
    end
  end

endmodule

[design/rbsi_div.sv]
// pipelined restoring divider, one quotient bit per stage on six lanes
// depends on rbsi_pkg
module rbsi_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  rbsi_pkg::div_pipe_t in_pipe,
  output logic                valid,
  output rbsi_pkg::div_pipe_t pipe
);

  localparam int STAGES = rbsi_pkg::NUM_W;

  rbsi_pkg::div_pipe_t stg [STAGES+1];
  logic                vld [STAGES+1];

  assign stg[0] = in_pipe;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    rbsi_pkg::div_pipe_t stg_next;

    always_comb begin
      logic [rbsi_pkg::DEN_W:0] r, diff;
      logic ge;
      stg_next = stg[s];
      for (int l = 0; l < rbsi_pkg::LANES; l++) begin
        r    = {stg[s].lane[l].rem, stg[s].lane[l].work[rbsi_pkg::NUM_W-1]};
        diff = r - {1'b0, stg[s].lane[l].den};
        ge   = ~diff[rbsi_pkg::DEN_W];
        stg_next.lane[l].rem  = ge ? diff[rbsi_pkg::DEN_W-1:0]
                                   : r[rbsi_pkg::DEN_W-1:0];
        stg_next.lane[l].work = {stg[s].lane[l].work[rbsi_pkg::NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg[s+1] <= stg_next;
      end
    end
  end

  assign valid = vld[STAGES];
  assign pipe  = stg[STAGES];

endmodule

[design/rbsi_resolve.sv]
// back end: signed slab distances, interval intersection, saturation
// three register stages, the last one is the output register; depends on rbsi_pkg
module rbsi_resolve (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  rbsi_pkg::div_pipe_t in_pipe,
  output logic                valid,
  output rbsi_pkg::out_t      out_data
);

  typedef logic signed [rbsi_pkg::T_W-1:0] tval_t;

  // stage a: per-axis ordered interval
  tval_t ent [rbsi_pkg::AXES];
  tval_t lve [rbsi_pkg::AXES];
  tval_t ent_next [rbsi_pkg::AXES];
  tval_t lve_next [rbsi_pkg::AXES];
  logic  miss_a, miss_a_next, valid_a;

  // stage b: intersection
  tval_t near_b, far_b, near_b_next, far_b_next;
  logic  miss_b, valid_b;

  rbsi_pkg::out_t out_next;

  always_comb begin
    tval_t q0, q1;
    miss_a_next = 1'b0;
    for (int a = 0; a < rbsi_pkg::AXES; a++) begin
      q0 = tval_t'({1'b0, in_pipe.lane[2*a].work});
      q1 = tval_t'({1'b0, in_pipe.lane[2*a+1].work});
      if (in_pipe.lane[2*a].neg) q0 = -q0;
      if (in_pipe.lane[2*a+1].neg) q1 = -q1;
      if (in_pipe.flag[a].unb) begin
        ent_next[a] = rbsi_pkg::NEG_UNB;
        lve_next[a] = rbsi_pkg::POS_UNB;
      end else if (q0 > q1) begin
        ent_next[a] = q1;
        lve_next[a] = q0;
      end else begin
        ent_next[a] = q0;
        lve_next[a] = q1;
      end
      miss_a_next |= in_pipe.flag[a].miss;
    end
  end

  always_comb begin
    near_b_next = ent[0];
    far_b_next  = lve[0];
    for (int a = 1; a < rbsi_pkg::AXES; a++) begin
      if (ent[a] > near_b_next) near_b_next = ent[a];
      if (lve[a] < far_b_next) far_b_next = lve[a];
    end
  end

  always_comb begin
    out_next = '0;
    if (!miss_b && near_b <= far_b) begin
      out_next.hit = 1'b1;
      out_next.t_near = (near_b > rbsi_pkg::SAT_HI) ? rbsi_pkg::SAT_HI[31:0] :
                        (near_b < rbsi_pkg::SAT_LO) ? rbsi_pkg::SAT_LO[31:0] :
                        near_b[31:0];
      out_next.t_far  = (far_b > rbsi_pkg::SAT_HI) ? rbsi_pkg::SAT_HI[31:0] :
                        (far_b < rbsi_pkg::SAT_LO) ? rbsi_pkg::SAT_LO[31:0] :
                        far_b[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid   <= 1'b0;
    end else if (adv) begin
      valid_a <= in_valid;
      valid_b <= valid_a;
      valid   <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent      <= ent_next;
      lve      <= lve_next;
      miss_a   <= miss_a_next;
      near_b   <= near_b_next;
      far_b    <= far_b_next;
      miss_b   <= miss_a;
      out_data <= out_next;
    end
  end

endmodule

[design/ray_box_slab_intersect_unit.sv]
// pipeline: 1 prep, 49 divider and 3 resolve register stages from input beat to result
// throughput: one beat per cycle; the whole pipeline holds while a result waits
// the six-lane divider is fully pipelined and retires one quotient bit per stage
// reset: synchronous rst clears every stage valid bit; no data is cleared
// top level of the ray versus axis-aligned box slab test
// depends on rbsi_pkg, rbsi_prep, rbsi_div, rbsi_resolve
module ray_box_slab_intersect_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rbsi_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rbsi_pkg::out_t out_data
);

  logic                adv;
  logic                prep_valid, div_valid;
  rbsi_pkg::div_pipe_t prep_pipe, div_pipe;

  // every stage moves together unless a finished result is held
  assign adv      = ~out_valid | out_ready;
  assign in_ready = adv;

  rbsi_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .valid    (prep_valid),
    .pipe     (prep_pipe)
  );

  rbsi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (prep_valid),
    .in_pipe  (prep_pipe),
    .valid    (div_valid),
    .pipe     (div_pipe)
  );

  rbsi_resolve u_resolve (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (div_valid),
    .in_pipe  (div_pipe),
    .valid    (out_valid),
    .out_data (out_data)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.t_near == 32'sd0 && out_data.t_far == 32'sd0)
    else $error("miss with nonzero distances");

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> out_data.t_near <= out_data.t_far)
    else $error("hit with near above far");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

[bench/testbench.sv]
// bench for ray_box_slab_intersect_unit: directed and random ray/box beats
// scoreboard fed by a slab-method predictor; depends on rbsi_pkg and the unit
module testbench;

  // beyond any slab distance the unit can form
  localparam logic signed [49:0] FAR_POS = 50'sd1 <<< 48;
  localparam logic signed [49:0] FAR_NEG = -(50'sd1 <<< 48);
  localparam int LATENCY = 53;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rbsi_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rbsi_pkg::out_t out_data;

  rbsi_pkg::out_t hit_queue[$];
  int errors = 0;
  bit quiet_phase = 1'b0;

  always #6 clk = ~clk;

  ray_box_slab_intersect_unit u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  function automatic logic signed [31:0] clamp32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // slab interval on one axis; returns 0 when this axis alone misses
  function automatic bit axis_span(input logic signed [31:0] lo, hi, org, dir,
                                   output logic signed [49:0] t_in, t_out);
    logic signed [63:0] d0, d1, q0, q1;
    d0 = (64'(lo) - 64'(org)) * 64'sd65536;
    d1 = (64'(hi) - 64'(org)) * 64'sd65536;
    if (dir == 0) begin
      t_in = FAR_NEG;
      t_out = FAR_POS;
      return !((org < lo && org < hi) || (org > lo && org > hi));
    end
    q0 = d0 / 64'(dir);
    q1 = d1 / 64'(dir);
    if (q0 > q1) begin
      t_in = q1[49:0];
      t_out = q0[49:0];
    end else begin
      t_in = q0[49:0];
      t_out = q1[49:0];
    end
    return 1'b1;
  endfunction

  function automatic rbsi_pkg::out_t predict_hit(input rbsi_pkg::in_t r);
    logic signed [31:0] lo[3], hi[3], org[3], dir[3];
    logic signed [49:0] near_t, far_t, a, b;
    rbsi_pkg::out_t res;
    bit ok;
    lo = '{r.box_min_x, r.box_min_y, r.box_min_z};
    hi = '{r.box_max_x, r.box_max_y, r.box_max_z};
    org = '{r.origin_x, r.origin_y, r.origin_z};
    dir = '{r.dir_x, r.dir_y, r.dir_z};
    near_t = FAR_NEG;
    far_t = FAR_POS;
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (!axis_span(lo[i], hi[i], org[i], dir[i], a, b)) ok = 1'b0;
      else begin
        if (a > near_t) near_t = a;
        if (b < far_t) far_t = b;
      end
    end
    if (near_t > far_t) ok = 1'b0;
    res = '0;
    if (ok) begin
      res.hit = 1'b1;
      res.t_near = clamp32(near_t);
      res.t_far = clamp32(far_t);
    end
    return res;
  endfunction

  // valid drops only while idling, so back-to-back beats keep it high
  task automatic send_ray(input rbsi_pkg::in_t r);
    while (!quiet_phase && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hit_queue = {hit_queue, predict_hit(r)};
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (hit_queue.size() == 0) begin
          $display("%0t unexpected result beat: actual %p", $time, out_data);
          errors++;
        end else begin
          rbsi_pkg::out_t want;
          want = hit_queue.pop_front();
          if (out_data.hit !== want.hit) begin
            $display("%0t hit: expected %0d actual %0d", $time, want.hit, out_data.hit);
            errors++;
          end
          if (out_data.t_near !== want.t_near) begin
            $display("%0t t_near: expected %0d actual %0d", $time, want.t_near,
                     out_data.t_near);
            errors++;
          end
          if (out_data.t_far !== want.t_far) begin
            $display("%0t t_far: expected %0d actual %0d", $time, want.t_far, out_data.t_far);
            errors++;
          end
        end
      end
      out_ready <= quiet_phase || ($urandom_range(99) >= 20);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(16);
    endcase
  endfunction

  function automatic rbsi_pkg::in_t make_box(input logic signed [31:0] c, half,
                                             logic signed [31:0] o, dx, dy, dz);
    rbsi_pkg::in_t r;
    r.box_min_x = c - half; r.box_min_y = c - half; r.box_min_z = c - half;
    r.box_max_x = c + half; r.box_max_y = c + half; r.box_max_z = c + half;
    r.origin_x = o; r.origin_y = o; r.origin_z = o;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  task automatic test_directed();
    rbsi_pkg::in_t r;
    send_ray(make_box(32'sh50000, 32'sh10000, 0, 32'sh10000, 32'sh10000, 32'sh10000));
    send_ray(make_box(32'sh50000, 32'sh10000, 0, -32'sh10000, 32'sh10000, 32'sh10000));
    // all directions zero, origin inside and outside
    send_ray(make_box(0, 32'sh10000, 0, 0, 0, 0));
    send_ray(make_box(32'sh50000, 32'sh10000, 0, 0, 0, 0));
    // zero direction on one axis only, origin on the boundary
    send_ray(make_box(32'sh10000, 32'sh10000, 0, 0, 32'sh8000, 1));
    // inverted box
    send_ray(make_box(32'sh50000, -32'sh10000, 0, 32'sh10000, 32'sh10000, 32'sh10000));
    // extremes, saturation both ways
    send_ray(make_box(0, 32'sh7fffffff, 32'sh80000000, 1, 1, 1));
    send_ray(make_box(0, 32'sh7fffffff, 32'sh7fffffff, -1, 32'sh80000000, 32'sh7fffffff));
    r = '1;
    send_ray(r);
    r = '0;
    send_ray(r);
    r = {12{32'h80000000}};
    send_ray(r);
    r = {12{32'h7fffffff}};
    send_ray(r);
    send_ray(make_box(32'sh100000, 32'sh10000, 0, 32'sh10000, 0, 32'sh10000));
  endtask

  task automatic test_random(input int n);
    rbsi_pkg::in_t r;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0) begin
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        // mostly aimed rays so hits are common
        r = make_box(pick_word() >>> 2, $urandom_range(32'h7ffff), pick_word() >>> 2,
                     pick_word(), pick_word(), pick_word());
        if ($urandom_range(1)) r.dir_x = r.box_min_x - r.origin_x + $urandom_range(255);
        if ($urandom_range(3) == 0) r.dir_y = 0;
        if ($urandom_range(3) == 0) r.origin_z = r.box_max_z;
      end
      send_ray(r);
    end
  endtask

  task automatic test_back_to_back(input int n);
    quiet_phase = 1'b1;
    test_random(n);
    quiet_phase = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_back_to_back(300);
    test_random(400);
    in_valid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
